/* design/adc_hysteresis_trigger_capture_defines.svh */
// Assertion macros shared by the checker of the ADC hysteresis trigger.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef ADC_HYSTERESIS_TRIGGER_CAPTURE_DEFINES_SVH
`define ADC_HYSTERESIS_TRIGGER_CAPTURE_DEFINES_SVH

// Property checked on every rising clock edge, muted during reset
`define AHTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen
`define AHTC_ASSERT_NEVER(lbl, cond, msg) \
  `AHTC_ASSERT(lbl, !(cond), msg)

`endif

/* design/ahtc_pkg.sv */
// Package for the ADC hysteresis trigger: level codes, per-channel state,
// threshold set, register indexes and reset values. No dependencies.
package ahtc_pkg;

  localparam int unsigned NumChan   = 2;
  localparam int unsigned SampleW   = 12;
  localparam int unsigned StampW    = 32;
  localparam int unsigned ThreshW   = 16;
  localparam int unsigned CfgAddrW  = 3;

  // Channel level status
  typedef enum logic [1:0] {
    LVL_MID  = 2'd0,
    LVL_HIGH = 2'd1,
    LVL_LOW  = 2'd2
  } level_e;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_LOW_CH0  = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_HIGH_CH0 = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_MID_CH0  = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_LOW_CH1  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_HIGH_CH1 = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_MID_CH1  = 3'd5;

  // Threshold reset values
  localparam logic [ThreshW-1:0] RST_LOW_CH0  = 16'd900;
  localparam logic [ThreshW-1:0] RST_HIGH_CH0 = 16'd2200;
  localparam logic [ThreshW-1:0] RST_MID_CH0  = 16'd1400;
  localparam logic [ThreshW-1:0] RST_LOW_CH1  = 16'd2700;
  localparam logic [ThreshW-1:0] RST_HIGH_CH1 = 16'd5000;
  localparam logic [ThreshW-1:0] RST_MID_CH1  = 16'd3000;

  typedef struct packed {
    logic [ThreshW-1:0] low;
    logic [ThreshW-1:0] high;
    logic [ThreshW-1:0] mid;
  } thresh_t;

  typedef struct packed {
    level_e              status;
    logic                trig_valid;
    logic [SampleW-1:0]  trig_value;
    logic [StampW-1:0]   trig_tick;
    logic [StampW-1:0]   trig_time;
  } chan_state_t;

endpackage

/* design/ahtc_cfg_regs.sv */
// Threshold register file for both channels, written through a plain write port.
// Depends on ahtc_pkg.
module ahtc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ahtc_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [ahtc_pkg::ThreshW-1:0]        cfg_wdata_i,
  output ahtc_pkg::thresh_t                   thr_o [ahtc_pkg::NumChan]
);

  ahtc_pkg::thresh_t thr_q [ahtc_pkg::NumChan];

  // Register writes; indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q[0] <= '{low: ahtc_pkg::RST_LOW_CH0, high: ahtc_pkg::RST_HIGH_CH0,
                    mid: ahtc_pkg::RST_MID_CH0};
      thr_q[1] <= '{low: ahtc_pkg::RST_LOW_CH1, high: ahtc_pkg::RST_HIGH_CH1,
                    mid: ahtc_pkg::RST_MID_CH1};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ahtc_pkg::CFG_LOW_CH0:  thr_q[0].low  <= cfg_wdata_i;
        ahtc_pkg::CFG_HIGH_CH0: thr_q[0].high <= cfg_wdata_i;
        ahtc_pkg::CFG_MID_CH0:  thr_q[0].mid  <= cfg_wdata_i;
        ahtc_pkg::CFG_LOW_CH1:  thr_q[1].low  <= cfg_wdata_i;
        ahtc_pkg::CFG_HIGH_CH1: thr_q[1].high <= cfg_wdata_i;
        ahtc_pkg::CFG_MID_CH1:  thr_q[1].mid  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign thr_o = thr_q;

endmodule

/* design/ahtc_chan_update.sv */
// Window comparator with hysteresis for one channel: next state and trigger flag.
// Depends on ahtc_pkg.
module ahtc_chan_update (
  input  ahtc_pkg::chan_state_t               cur_i,
  input  ahtc_pkg::thresh_t                   thr_i,
  input  logic [ahtc_pkg::SampleW-1:0]        sample_i,
  input  logic [ahtc_pkg::StampW-1:0]         tick_i,
  input  logic [ahtc_pkg::StampW-1:0]         wall_i,
  output ahtc_pkg::chan_state_t               nxt_o,
  output logic                                fired_o
);

  logic [ahtc_pkg::ThreshW-1:0] sample_ext;

  assign sample_ext = {{(ahtc_pkg::ThreshW - ahtc_pkg::SampleW){1'b0}}, sample_i};

  // High test wins over low test, which wins over the return to mid
  always_comb begin
    nxt_o   = cur_i;
    fired_o = 1'b0;
    priority if (sample_ext > thr_i.high) begin
      if (cur_i.status != ahtc_pkg::LVL_HIGH) begin
        fired_o      = 1'b1;
        nxt_o.status = ahtc_pkg::LVL_HIGH;
      end
    end else if (sample_ext < thr_i.low) begin
      if (cur_i.status != ahtc_pkg::LVL_LOW) begin
        fired_o      = 1'b1;
        nxt_o.status = ahtc_pkg::LVL_LOW;
      end
    end else if ((cur_i.status == ahtc_pkg::LVL_HIGH && sample_ext < thr_i.mid) ||
                 (cur_i.status == ahtc_pkg::LVL_LOW  && sample_ext > thr_i.mid)) begin
      nxt_o.status = ahtc_pkg::LVL_MID;
      // return within the capture tick: treat the trigger as noise
      if (cur_i.trig_valid && cur_i.trig_tick == tick_i) begin
        nxt_o.trig_valid = 1'b0;
      end
    end else begin
      // inside the hysteresis band: state holds
    end

    // capture on a new trigger
    if (fired_o) begin
      nxt_o.trig_valid = 1'b1;
      nxt_o.trig_value = sample_i;
      nxt_o.trig_tick  = tick_i;
      nxt_o.trig_time  = wall_i;
    end
  end

endmodule

/* design/adc_hysteresis_trigger_capture.sv */
// Two-channel ADC level trigger with hysteresis and time-stamped capture.
// Each accepted transaction passes the input register and then the result register.
// Throughput: one transaction per cycle while the output is not stalled; the channel
// state is updated as the item leaves the input register, so back-to-back samples of
// one channel chain correctly. Reset (rst_ni, async, active low): both channels mid,
// no captures, captures zero, thresholds at their default values, both pipeline stages empty.
module adc_hysteresis_trigger_capture (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // [11:0] sample, [43:12] tick_ms, [75:44] wall_time
  input  logic        s_axis_tuser,   // [0] channel
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [11:0] captured_value, [43:12] captured_tick,
                                      // [75:44] captured_time
  output logic [3:0]  m_axis_tuser    // [1:0] level_state, [2] new_trigger, [3] trigger_valid
);

  localparam int unsigned SW = ahtc_pkg::SampleW;
  localparam int unsigned TW = ahtc_pkg::StampW;

  ahtc_pkg::thresh_t     thr [ahtc_pkg::NumChan];
  ahtc_pkg::chan_state_t st_q [ahtc_pkg::NumChan];
  ahtc_pkg::chan_state_t nxt_st;
  logic                  fired;

  logic          in_vld_q;
  logic          in_chan_q;
  logic [SW-1:0] in_sample_q;
  logic [TW-1:0] in_tick_q;
  logic [TW-1:0] in_wall_q;

  logic                  out_vld_q;
  logic                  out_new_q;
  ahtc_pkg::chan_state_t out_st_q;

  logic advance;

  ahtc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  // Handshake: stage 2 moves when the result register is free or being taken
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_chan_q   <= s_axis_tuser;
      in_sample_q <= s_axis_tdata[SW-1:0];
      in_tick_q   <= s_axis_tdata[SW+TW-1:SW];
      in_wall_q   <= s_axis_tdata[SW+2*TW-1:SW+TW];
    end
  end

  ahtc_chan_update u_upd (
    .cur_i    (st_q[in_chan_q]),
    .thr_i    (thr[in_chan_q]),
    .sample_i (in_sample_q),
    .tick_i   (in_tick_q),
    .wall_i   (in_wall_q),
    .nxt_o    (nxt_st),
    .fired_o  (fired)
  );

  // Channel state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < ahtc_pkg::NumChan; c++) begin
        st_q[c] <= '{status: ahtc_pkg::LVL_MID, trig_valid: 1'b0,
                     trig_value: '0, trig_tick: '0, trig_time: '0};
      end
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        st_q[in_chan_q] <= nxt_st;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_st_q  <= nxt_st;
      out_new_q <= fired;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_st_q.trig_time, out_st_q.trig_tick,
                          out_st_q.trig_value};
  assign m_axis_tuser  = {out_st_q.trig_valid, out_new_q, out_st_q.status};

endmodule

/* design/ahtc_checker.sv */
// Port-level checker for the ADC hysteresis trigger, bound to the top level.
// Depends on adc_hysteresis_trigger_capture_defines.svh.
`include "adc_hysteresis_trigger_capture_defines.svh"

module ahtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  // a stalled result transaction keeps its contents
  `AHTC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // only three level codes exist
  `AHTC_ASSERT_NEVER(a_level_code, m_axis_tvalid && m_axis_tuser[1:0] == 2'd3, "bad level code")

  // a new trigger leaves a valid capture and a non-mid level
  `AHTC_ASSERT(a_trig_state, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[3] && m_axis_tuser[1:0] != 2'd0, "trigger without capture")

  // input side stalls only behind a full result register
  `AHTC_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled with free output")

endmodule

bind adc_hysteresis_trigger_capture ahtc_checker u_ahtc_checker (.*);

/* tb/adc_hysteresis_trigger_capture_checker.sv */
// Checker for the two-channel ADC hysteresis trigger: tracks threshold writes,
// predicts one result per accepted sample and compares results field by field.
// Depends on ahtc_pkg for level codes, register indexes and state types.
module adc_hysteresis_trigger_capture_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // [11:0] sample, [43:12] tick_ms, [75:44] wall_time
  input  logic        s_axis_tuser,   // [0] channel
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,   // [11:0] captured_value, [43:12] captured_tick,
                                      // [75:44] captured_time
  input  logic [3:0]  m_axis_tuser,   // [1:0] level_state, [2] new_trigger, [3] trigger_valid
  output int          fail_count_o,
  output int          pending_o
);

  // One predicted result transaction
  typedef struct packed {
    ahtc_pkg::level_e                level;
    logic                            fresh;
    logic                            held;
    logic [ahtc_pkg::SampleW-1:0]    value;
    logic [ahtc_pkg::StampW-1:0]     tick;
    logic [ahtc_pkg::StampW-1:0]     wall;
  } trig_result_t;

  ahtc_pkg::thresh_t      thr  [ahtc_pkg::NumChan];
  ahtc_pkg::chan_state_t  chan [ahtc_pkg::NumChan];
  trig_result_t           capture_q [$];
  int                     mismatches;

  // Window compare with hysteresis for one sample; updates the channel state
  function automatic trig_result_t step_trigger(logic ch,
                                                logic [ahtc_pkg::SampleW-1:0] smp,
                                                logic [ahtc_pkg::StampW-1:0] tick,
                                                logic [ahtc_pkg::StampW-1:0] wall);
    ahtc_pkg::chan_state_t        cs;
    ahtc_pkg::thresh_t            th;
    logic [ahtc_pkg::ThreshW-1:0] v;
    logic                         fired;
    ahtc_pkg::level_e             target;
    trig_result_t                 r;
    cs     = chan[ch];
    th     = thr[ch];
    v      = {{(ahtc_pkg::ThreshW - ahtc_pkg::SampleW){1'b0}}, smp};
    fired  = 1'b0;
    target = ahtc_pkg::LVL_MID;
    // high test wins over low test, both win over the return to mid
    if (v > th.high) begin
      if (cs.status != ahtc_pkg::LVL_HIGH) begin
        fired  = 1'b1;
        target = ahtc_pkg::LVL_HIGH;
      end
    end else if (v < th.low) begin
      if (cs.status != ahtc_pkg::LVL_LOW) begin
        fired  = 1'b1;
        target = ahtc_pkg::LVL_LOW;
      end
    end else if ((cs.status == ahtc_pkg::LVL_HIGH && v < th.mid) ||
                 (cs.status == ahtc_pkg::LVL_LOW  && v > th.mid)) begin
      cs.status = ahtc_pkg::LVL_MID;
      // back to mid within the capture tick: drop the capture as noise
      if (cs.trig_valid && cs.trig_tick == tick) cs.trig_valid = 1'b0;
    end
    if (fired) begin
      cs.status     = target;
      cs.trig_valid = 1'b1;
      cs.trig_value = smp;
      cs.trig_tick  = tick;
      cs.trig_time  = wall;
    end
    chan[ch] = cs;
    r.level = cs.status;
    r.fresh = fired;
    r.held  = cs.trig_valid;
    r.value = cs.trig_value;
    r.tick  = cs.trig_tick;
    r.wall  = cs.trig_time;
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  // Track config writes, queue predictions, compare results in order
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    trig_result_t want;
    if (!rst_ni) begin
      thr[0] = '{low: ahtc_pkg::RST_LOW_CH0, high: ahtc_pkg::RST_HIGH_CH0,
                 mid: ahtc_pkg::RST_MID_CH0};
      thr[1] = '{low: ahtc_pkg::RST_LOW_CH1, high: ahtc_pkg::RST_HIGH_CH1,
                 mid: ahtc_pkg::RST_MID_CH1};
      for (int c = 0; c < ahtc_pkg::NumChan; c++) begin
        chan[c]        = '0;
        chan[c].status = ahtc_pkg::LVL_MID;
      end
      capture_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ahtc_pkg::CFG_LOW_CH0:  thr[0].low  = cfg_wdata_i;
          ahtc_pkg::CFG_HIGH_CH0: thr[0].high = cfg_wdata_i;
          ahtc_pkg::CFG_MID_CH0:  thr[0].mid  = cfg_wdata_i;
          ahtc_pkg::CFG_LOW_CH1:  thr[1].low  = cfg_wdata_i;
          ahtc_pkg::CFG_HIGH_CH1: thr[1].high = cfg_wdata_i;
          ahtc_pkg::CFG_MID_CH1:  thr[1].mid  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        capture_q.push_back(step_trigger(s_axis_tuser, s_axis_tdata[11:0],
                                         s_axis_tdata[43:12], s_axis_tdata[75:44]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (capture_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result transaction with nothing expected: user 0x%0h data 0x%0h",
                     $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = capture_q.pop_front();
          check_field("level_state",    32'(want.level), 32'(m_axis_tuser[1:0]));
          check_field("new_trigger",    32'(want.fresh), 32'(m_axis_tuser[2]));
          check_field("trigger_valid",  32'(want.held),  32'(m_axis_tuser[3]));
          check_field("captured_value", 32'(want.value), 32'(m_axis_tdata[11:0]));
          check_field("captured_tick",  want.tick,       m_axis_tdata[43:12]);
          check_field("captured_time",  want.wall,       m_axis_tdata[75:44]);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= capture_q.size();
    end
  end

endmodule

/* tb/adc_hysteresis_trigger_capture_tb.sv */
// Top of the ADC hysteresis trigger testbench: clock, reset, threshold writes,
// sample stimulus, result back-pressure, watchdog and verdict.
// Depends on ahtc_pkg, the block and adc_hysteresis_trigger_capture_checker.
module adc_hysteresis_trigger_capture_tb;

  localparam int unsigned     PIPE_LATENCY   = 2;
  localparam int unsigned     WATCHDOG_LIMIT = 5000;
  localparam int unsigned     PRESSURE_HOLD  = 300;
  localparam int unsigned     PHASE_ITEMS    = 170;
  localparam logic [2:0]      CFG_SPARE_6    = 3'd6;
  localparam logic [2:0]      CFG_SPARE_7    = 3'd7;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_addr      = '0;
  logic [15:0] cfg_wdata     = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  int                 fail_count;
  int                 pending;
  int unsigned        idle_cycles   = 0;
  logic               squeeze_req   = 1'b0;
  logic               squeeze_done  = 1'b0;
  logic [31:0]        cur_tick      = '0;
  ahtc_pkg::thresh_t  levels [ahtc_pkg::NumChan];

  adc_hysteresis_trigger_capture u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  adc_hysteresis_trigger_capture_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: too long without any transaction or register write
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side back-pressure: changing stall modes plus one long hold-off
  initial begin : rx_pattern
    int unsigned mode;
    int unsigned span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        m_axis_tready <= 1'b0;
        repeat (PRESSURE_HOLD - 1) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(32, 256);
        end
        span--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 9) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 9) < 3);
          default: m_axis_tready <= ((span % 5) != 0);
        endcase
      end
    end
  end

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input logic ch, input logic [11:0] smp,
                             input logic [31:0] tick, input logic [31:0] wall);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ch;
    s_axis_tdata  <= {4'd0, wall, tick, smp};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Wait until every predicted result has come out, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Write all six thresholds plus the two unused indexes, back to back
  task automatic set_levels(input logic [15:0] l0, h0, m0, l1, h1, m1);
    logic [2:0]  addr_seq [8];
    logic [15:0] data_seq [8];
    addr_seq = '{ahtc_pkg::CFG_LOW_CH0, ahtc_pkg::CFG_HIGH_CH0, ahtc_pkg::CFG_MID_CH0,
                 ahtc_pkg::CFG_LOW_CH1, ahtc_pkg::CFG_HIGH_CH1, ahtc_pkg::CFG_MID_CH1,
                 CFG_SPARE_6, CFG_SPARE_7};
    data_seq = '{l0, h0, m0, l1, h1, m1, 16'($urandom), 16'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addr_seq[i];
      cfg_wdata <= data_seq[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    levels[0] = '{low: l0, high: h0, mid: m0};
    levels[1] = '{low: l1, high: h1, mid: m1};
  endtask

  // Samples cluster around the current thresholds so states keep flipping
  function automatic logic [11:0] pick_sample(logic ch);
    int unsigned r;
    int unsigned base;
    int unsigned pick;
    r = $urandom_range(0, 9);
    if (r < 3) return 12'($urandom_range(0, 4095));
    if (r == 3) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    case ($urandom_range(0, 2))
      0:       base = levels[ch].low;
      1:       base = levels[ch].high;
      default: base = levels[ch].mid;
    endcase
    pick = base + $urandom_range(0, 8);
    pick = (pick < 4) ? 0 : pick - 4;
    if (pick > 4095) pick = 4095;
    return pick[11:0];
  endfunction

  // Tick mostly holds or steps by one, so same-tick returns happen often
  task automatic advance_tick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)      cur_tick = cur_tick;
    else if (r < 95) cur_tick = cur_tick + 1;
    else if (r < 98) cur_tick = cur_tick + $urandom_range(2, 1000);
    else             cur_tick = $urandom;
  endtask

  // Random samples in bursts with random gaps
  task automatic run_phase(input int unsigned n_items);
    int unsigned burst;
    logic        ch;
    burst = 0;
    repeat (n_items) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      advance_tick();
      ch = 1'($urandom_range(0, 1));
      send_sample(ch, pick_sample(ch), cur_tick, $urandom);
      burst--;
    end
  endtask

  initial begin
    levels[0] = '{low: ahtc_pkg::RST_LOW_CH0, high: ahtc_pkg::RST_HIGH_CH0,
                  mid: ahtc_pkg::RST_MID_CH0};
    levels[1] = '{low: ahtc_pkg::RST_LOW_CH1, high: ahtc_pkg::RST_HIGH_CH1,
                  mid: ahtc_pkg::RST_MID_CH1};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, default thresholds: ch0 900/2200/1400, ch1 2700/5000/3000
    send_sample(1'b0, 12'd0,    32'd0, 32'hFFFF_FFFF);  // low capture, minimum sample
    send_sample(1'b0, 12'd1500, 32'd0, 32'h0000_0000);  // back to mid same tick: cancel
    send_sample(1'b0, 12'd4095, 32'd5, 32'hA5A5_5A5A);  // high capture, maximum sample
    send_sample(1'b0, 12'd100,  32'd6, 32'h5A5A_A5A5);  // high straight to low
    send_sample(1'b0, 12'd4000, 32'd7, 32'h1234_5678);  // low straight to high
    send_sample(1'b0, 12'd1000, 32'd8, 32'h0);          // mid on a later tick, capture kept
    send_sample(1'b0, 12'd1400, 32'd8, 32'h0);          // inside the window, no change
    send_sample(1'b1, 12'd4095, 32'hFFFF_FFFF, 32'hAAAA_AAAA); // ch1 high level out of range
    send_sample(1'b1, 12'd2699, 32'hFFFF_FFFF, 32'h5555_5555); // ch1 low capture
    send_sample(1'b1, 12'd3001, 32'd0, 32'h0);          // ch1 mid on a later tick
    send_sample(1'b1, 12'd2699, 32'd0, 32'hFFFF_0000);  // ch1 low capture again
    send_sample(1'b1, 12'd2699, 32'd0, 32'h0);          // already low, nothing new
    send_sample(1'b1, 12'd3000, 32'd0, 32'h0);          // at mid level, stays low
    send_sample(1'b1, 12'd3001, 32'd0, 32'h0);          // above mid same tick: cancel
    send_sample(1'b0, 12'd2201, 32'd9, 32'h0000_FFFF);  // just above high level
    send_sample(1'b0, 12'd2200, 32'd9, 32'h0);          // at high level, stays high
    send_sample(1'b0, 12'd899,  32'd9, 32'h0F0F_0F0F);  // just below low: direct swing
    send_sample(1'b0, 12'd1401, 32'd9, 32'h0);          // just above mid same tick: cancel
    drain();

    // All zero: high on anything but zero, never low
    set_levels(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(PHASE_ITEMS);
    drain();

    // All ones: never high, always low
    set_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(PHASE_ITEMS);
    drain();

    // Overlapping windows, high test must win; long receiver hold-off here
    squeeze_req <= 1'b1;
    set_levels(16'd3000, 16'd1000, 16'd2000, 16'd4095, 16'd0, 16'd2048);
    run_phase(PHASE_ITEMS);
    drain();

    // Narrow hysteresis
    set_levels(16'd1000, 16'd1100, 16'd1050, 16'd2000, 16'd2010, 16'd2005);
    run_phase(PHASE_ITEMS);
    drain();

    // Random ordered windows
    begin
      logic [15:0] lo0, hi0, lo1, hi1;
      lo0 = 16'($urandom_range(0, 3000));
      hi0 = lo0 + 16'($urandom_range(0, 1000));
      lo1 = 16'($urandom_range(0, 3000));
      hi1 = lo1 + 16'($urandom_range(0, 1000));
      set_levels(lo0, hi0, 16'($urandom_range(lo0, hi0)),
                 lo1, hi1, 16'($urandom_range(lo1, hi1)));
    end
    run_phase(PHASE_ITEMS);
    drain();

    // Back to the reset values
    set_levels(ahtc_pkg::RST_LOW_CH0, ahtc_pkg::RST_HIGH_CH0, ahtc_pkg::RST_MID_CH0,
               ahtc_pkg::RST_LOW_CH1, ahtc_pkg::RST_HIGH_CH1, ahtc_pkg::RST_MID_CH1);
    run_phase(PHASE_ITEMS);
    drain();

    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
